@@ rtl/rtkm_pkg.sv @@
package rtkm_pkg;

   localparam int NODE_COUNT       = 64;
   localparam int ENTRIES_PER_NODE = 256;
   localparam int DATA_W           = 32;
   localparam int KEY_W            = 32;
   localparam int BYTE_W           = $clog2(ENTRIES_PER_NODE);
   localparam int NODE_W           = $clog2(NODE_COUNT);
   localparam int CNT_W            = $clog2(NODE_COUNT + 1);
   localparam int ADDR_W           = NODE_W + BYTE_W;
   localparam int STORE_DEPTH      = NODE_COUNT * ENTRIES_PER_NODE;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

   // operation codes on req_tuser
   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   // status codes on rsp_tuser
   localparam logic STAT_DONE      = 1'b0;
   localparam logic STAT_POOL_FULL = 1'b1;

   typedef struct packed {
      logic              is_get;
      logic [KEY_W-1:0]  map_key;
      logic [DATA_W-1:0] put_value;
   } item_type;

   // engine -> front control
   typedef struct packed {
      logic pop;
      logic clear_busy;
   } eng_ctl_type;

   // key byte for a trie level, most significant byte at level 0
   function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                  input logic [1:0] level);
      logic [KEY_W-1:0] shifted;
      begin
         case (level)
            2'd0:    shifted = key >> 24;
            2'd1:    shifted = key >> 16;
            2'd2:    shifted = key >> 8;
            default: shifted = key;
         endcase
         key_byte = shifted[BYTE_W-1:0] & 8'hFF;
      end
   endfunction

endpackage

@@ rtl/rtkm_ram.sv @@
module rtkm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/rtkm_front.sv @@
module rtkm_front
   import rtkm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // map_key [31:0], put_value [63:32]
   input  logic         req_tuser,   // cmd
   input  eng_ctl_type  eng_ctl,
   output logic         q_valid,
   output item_type     q_item
);

   item_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               pop;
   item_type           new_item;

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH)) && !eng_ctl.clear_busy;
   assign push       = req_tvalid && req_tready;
   assign pop        = eng_ctl.pop && q_valid;
   assign q_valid    = (count_ff != '0);
   assign q_item     = queue_ff[rd_ptr_ff];

   // classify: decode the operation once here
   always_comb begin
      new_item.is_get    = (req_tuser == CMD_GET);
      new_item.map_key   = req_tdata[31:0];
      new_item.put_value = req_tdata[63:32];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/rtkm_engine.sv @@
module rtkm_engine
   import rtkm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output eng_ctl_type        eng_ctl,
   output logic               ram_we,
   output logic [ADDR_W-1:0]  ram_addr,
   output logic [DATA_W-1:0]  ram_wdata,
   input  logic [DATA_W-1:0]  ram_rdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [DATA_W-1:0]  rsp_tdata,
   output logic               rsp_tuser
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]   in_use_ff, in_use_in;
   logic               is_get_ff, is_get_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [1:0]         level_ff, level_in;
   logic [DATA_W-1:0]  res_value_ff, res_value_in;
   logic               res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_status_ff, rsp_status_in;

   logic [BYTE_W-1:0]  cur_byte;
   logic [ADDR_W-1:0]  cur_addr;
   logic [NODE_W-1:0]  link_node;
   logic               pool_full;
   logic               rsp_load;

   assign cur_byte  = key_byte(key_ff, level_ff);
   assign cur_addr  = {node_ff, cur_byte};
   // a link at or above the pool size counts as absent
   assign link_node = (ram_rdata < DATA_W'(NODE_COUNT)) ? ram_rdata[NODE_W-1:0] : '0;
   assign pool_full = (in_use_ff >= CNT_W'(NODE_COUNT));
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      in_use_in     = in_use_ff;
      is_get_in     = is_get_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      node_in       = node_ff;
      level_in      = level_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      ram_we        = 1'b0;
      ram_addr      = cur_addr;
      ram_wdata     = value_ff;
      eng_ctl.pop        = 1'b0;
      eng_ctl.clear_busy = (state_ff == ST_CLEAR);

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_addr    = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               eng_ctl.pop = 1'b1;
               is_get_in   = q_item.is_get;
               key_in      = q_item.map_key;
               value_in    = q_item.put_value;
               node_in     = '0;
               level_in    = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            if (!is_get_ff && (level_ff == 2'd3)) begin
               // leaf write for a put
               ram_we        = 1'b1;
               ram_wdata     = value_ff;
               res_value_in  = '0;
               res_status_in = STAT_DONE;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (level_ff == 2'd3) begin
               res_value_in  = ram_rdata;
               res_status_in = STAT_DONE;
               state_in      = ST_DONE;
            end else if (link_node != '0) begin
               node_in  = link_node;
               level_in = level_ff + 1'b1;
               state_in = ST_READ;
            end else if (is_get_ff) begin
               res_value_in  = '0;
               res_status_in = STAT_DONE;
               state_in      = ST_DONE;
            end else if (pool_full) begin
               res_value_in  = '0;
               res_status_in = STAT_POOL_FULL;
               state_in      = ST_DONE;
            end else begin
               // hand out the next node and link it in
               ram_we    = 1'b1;
               ram_wdata = DATA_W'(in_use_ff);
               node_in   = in_use_ff[NODE_W-1:0];
               in_use_in = in_use_ff + 1'b1;
               level_in  = level_ff + 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         in_use_ff    <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_get_ff     <= is_get_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      node_ff       <= node_in;
      level_ff      <= level_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ rtl/radix_trie_key_map.sv @@
// Key/value map of 32-bit keys onto 32-bit values, kept as a four-level trie with
// 256 entries per node in one single-port store of NODE_COUNT * 256 words. Each
// request word is a put (req_tuser = 0) or a get (req_tuser = 1); every request
// gives exactly one response word, in order. A get returns the stored value, or 0
// if the key was never put. A put returns 0; its rsp_tuser is 1 when the node pool
// ran out, in which case links already made stay and the value is not written.
// After reset the store is swept to zero, one word a cycle, over all NODE_COUNT *
// 256 words (16384 at the default); req_tready stays low until the sweep is done.
// The walk engine then takes each request through these steps: one dispatch, a
// read issue and a read return for each of the three link levels, the leaf write
// (put) or leaf read issue and return (get), and a hand-off of the result to the
// output register. A get that meets a zero link, or a put that runs out of nodes,
// stops early at level 0, 1 or 2. The hand-off waits while the output register
// holds an untaken word. The reads are dependent and go through the single store
// port. A two-word request queue in front of the engine and the response register
// behind it let either side stall without holding up the other.
module radix_trie_key_map
   import rtkm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // map_key [31:0], put_value [63:32]
   input  logic         req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // read_value [31:0]
   output logic         rsp_tuser    // status
);

   eng_ctl_type        eng_ctl;
   logic               q_valid;
   item_type           q_item;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [DATA_W-1:0]  ram_wdata;
   logic [DATA_W-1:0]  ram_rdata;

   // front: accepts and classifies request words into a short queue
   rtkm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .eng_ctl    (eng_ctl),
      .q_valid    (q_valid),
      .q_item     (q_item)
   );

   // back: clears the store after reset, then walks the trie per item
   rtkm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .eng_ctl    (eng_ctl),
      .ram_we     (ram_we),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // node store: links in levels 0..2, values at the leaves
   rtkm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

@@ rtl/rtkm_check.sv @@
module rtkm_check
   import rtkm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   input  logic         rsp_tuser
);

   localparam int MAX_OPEN = QUEUE_DEPTH + 2;
   localparam int OPEN_W   = $clog2(MAX_OPEN + 1);

   logic [OPEN_W-1:0] open_ff, open_in;
   logic              req_acc;
   logic              rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      open_in = open_ff;
      if (req_acc && !rsp_acc) begin
         open_in = open_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // store sweep keeps requests out right after reset
   a_no_req_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request taken during store clear");

   // no response without an outstanding request
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (open_ff != '0))
      else $error("response word with no open request");

   // queue, engine and output register bound the open requests
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= OPEN_W'(MAX_OPEN))
      else $error("too many open requests");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

endmodule

bind radix_trie_key_map rtkm_check u_check (.*);
